FILE: src/lrmf_pkg.sv
// ----------------------------------------------------------------------------
// lrmf_pkg
// Shared types, constants and helpers for the line pattern match filter.
// ----------------------------------------------------------------------------
package lrmf_pkg;

  // Default sizing
  localparam int DEF_PATTERN_ELEMENTS = 8;
  localparam int DEF_LINE_LIMIT       = 4096;
  localparam int RES_DEPTH            = 8;

  // Character codes
  localparam logic [7:0]  CHAR_NL     = 8'h0A;
  localparam logic [7:0]  CHAR_NUL    = 8'h00;
  localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0]  CASE_OFFSET = 8'd32;
  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CHARS    = 3'd0,
    CFG_ANY      = 3'd1,
    CFG_STAR     = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_ANCHORED = 3'd4,
    CFG_ICASE    = 3'd5,
    CFG_INVERT   = 3'd6
  } cfg_idx_t;

  // Input beat kind
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // Configuration register file
  typedef struct packed {
    logic [63:0] chars;
    logic [7:0]  any;
    logic [7:0]  star;
    logic [3:0]  length;
    logic        anchored;
    logic        icase;
    logic        invert;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic        is_summary;
    logic        line_selected;
    logic [31:0] line_number;
    logic [31:0] selected_count;
    logic        exit_status;
    logic        last;
  } res_t;

  // Result push strobes: second only ever with first
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // ASCII case fold
  function automatic logic [7:0] fold(input logic [7:0] c, input logic icase);
    logic [7:0] r;
    r = c;
    if (icase && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: src/lrmf_core.sv
// ----------------------------------------------------------------------------
// lrmf_core
// Input register, line state and bit-parallel pattern position update.
// Produces up to two result beats per processed input beat.
// ----------------------------------------------------------------------------
module lrmf_core #(
  parameter int PATTERN_ELEMENTS = lrmf_pkg::DEF_PATTERN_ELEMENTS,
  parameter int LINE_LIMIT       = lrmf_pkg::DEF_LINE_LIMIT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_load,
  input  logic            in_kind,
  input  logic [7:0]      in_byte,
  input  lrmf_pkg::cfg_t  cfg,
  output logic            busy,
  output lrmf_pkg::push_t push,
  output lrmf_pkg::res_t  res0,
  output lrmf_pkg::res_t  res1
);

  localparam int N  = PATTERN_ELEMENTS;
  localparam int NW = $clog2(N + 1);
  localparam int LW = $clog2(LINE_LIMIT);

  // Input register
  logic                  s1_valid_r;
  lrmf_pkg::kind_t       s1_kind_r;
  logic [7:0]            s1_byte_r;

  // Line state
  logic [N:0]            act_r,   act_nxt;
  logic                  found_r, found_nxt;
  logic                  nul_r,   nul_nxt;
  logic [LW-1:0]         len_r,   len_nxt;
  logic [31:0]           lines_r, lines_nxt;
  logic [31:0]           sel_r,   sel_nxt;

  // Combinational
  logic [NW-1:0]         pat_n;
  logic [N:0]            cur_end;
  logic                  line_hit;
  logic [31:0]           lines_inc;
  logic [31:0]           sel_inc;
  logic                  is_data;
  logic                  is_nl;
  logic                  full;
  logic                  line_end;
  logic [N:0]            f_act;
  logic                  f_found;
  logic                  f_nul;
  logic [LW-1:0]         f_len;
  logic [N:0]            cur_f;
  logic [N:0]            step_vec;
  logic [7:0]            tb;
  lrmf_pkg::res_t        res_line;
  lrmf_pkg::res_t        res_sum;

  // Star closure over the first n elements, in element order
  function automatic logic [N:0] closure(input logic [N:0] s, input logic [7:0] star,
                                         input logic [NW-1:0] n);
    logic [N:0] r;
    r = s;
    for (int i = 0; i < N; i++) begin
      if ((NW'(i) < n) && r[i] && star[i]) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  assign busy = s1_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_load;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_kind_r <= lrmf_pkg::kind_t'(in_kind);
      s1_byte_r <= in_byte;
    end
  end

  // Line termination and match verdict on the current state
  always_comb begin
    pat_n      = (cfg.length > 4'(N)) ? NW'(N) : cfg.length[NW-1:0];
    cur_end    = closure(act_r, cfg.star, pat_n);
    line_hit   = (found_r | cur_end[pat_n]) ^ cfg.invert;
    lines_inc  = (lines_r != lrmf_pkg::CNT_MAX) ? lines_r + 32'd1 : lines_r;
    sel_inc    = (line_hit && (sel_r != lrmf_pkg::CNT_MAX)) ? sel_r + 32'd1 : sel_r;
    is_data    = (s1_kind_r == lrmf_pkg::KIND_DATA);
    is_nl      = (s1_byte_r == lrmf_pkg::CHAR_NL);
    full       = (len_r >= LW'(LINE_LIMIT - 1));
    line_end   = is_data ? (is_nl | full) : (len_r != '0);
  end

  // Byte step: a full line restarts from a fresh line first
  always_comb begin
    f_act   = full ? (N+1)'(1) : act_r;
    f_found = full ? 1'b0 : found_r;
    f_nul   = full ? 1'b0 : nul_r;
    f_len   = full ? '0 : len_r;
    cur_f   = closure(f_act, cfg.star, pat_n);
    tb      = lrmf_pkg::fold(s1_byte_r, cfg.icase);
    step_vec = '0;
    for (int i = 0; i < N; i++) begin
      if ((NW'(i) < pat_n) && cur_f[i] &&
          (cfg.any[i] || (lrmf_pkg::fold(cfg.chars[8*i +: 8], cfg.icase) == tb))) begin
        if (cfg.star[i]) begin
          step_vec[i] = 1'b1;
        end else begin
          step_vec[i+1] = 1'b1;
        end
      end
    end
    if (!cfg.anchored) begin
      step_vec[0] = 1'b1;
    end
  end

  // Next state
  always_comb begin
    act_nxt   = act_r;
    found_nxt = found_r;
    nul_nxt   = nul_r;
    len_nxt   = len_r;
    lines_nxt = lines_r;
    sel_nxt   = sel_r;
    if (s1_valid_r) begin
      if (!is_data) begin
        // end of input: whole stream state back to reset
        act_nxt   = (N+1)'(1);
        found_nxt = 1'b0;
        nul_nxt   = 1'b0;
        len_nxt   = '0;
        lines_nxt = '0;
        sel_nxt   = '0;
      end else if (is_nl) begin
        act_nxt   = (N+1)'(1);
        found_nxt = 1'b0;
        nul_nxt   = 1'b0;
        len_nxt   = '0;
        lines_nxt = lines_inc;
        sel_nxt   = sel_inc;
      end else begin
        if (full) begin
          lines_nxt = lines_inc;
          sel_nxt   = sel_inc;
        end
        len_nxt   = f_len + LW'(1);
        act_nxt   = f_act;
        found_nxt = f_found;
        nul_nxt   = f_nul;
        if (!f_nul) begin
          found_nxt = f_found | cur_f[pat_n];
          if (s1_byte_r == lrmf_pkg::CHAR_NUL) begin
            nul_nxt = 1'b1;
          end else begin
            act_nxt = step_vec;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= (N+1)'(1);
      found_r <= 1'b0;
      nul_r   <= 1'b0;
      len_r   <= '0;
      lines_r <= '0;
      sel_r   <= '0;
    end else begin
      act_r   <= act_nxt;
      found_r <= found_nxt;
      nul_r   <= nul_nxt;
      len_r   <= len_nxt;
      lines_r <= lines_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Result beats
  always_comb begin
    res_line.is_summary     = 1'b0;
    res_line.line_selected  = line_hit;
    res_line.line_number    = lines_inc;
    res_line.selected_count = sel_inc;
    res_line.exit_status    = (sel_inc == '0);
    res_line.last           = is_data;

    res_sum.is_summary      = 1'b1;
    res_sum.line_selected   = 1'b0;
    res_sum.line_number     = line_end ? lines_inc : lines_r;
    res_sum.selected_count  = line_end ? sel_inc : sel_r;
    res_sum.exit_status     = (res_sum.selected_count == '0);
    res_sum.last            = 1'b1;

    res0        = line_end ? res_line : res_sum;
    res1        = res_sum;
    push.first  = s1_valid_r & (line_end | !is_data);
    push.second = s1_valid_r & !is_data & line_end;
  end

`ifndef SYNTHESIS
  // selected lines never outrun lines seen
  a_sel_le_lines: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r <= lines_r)
    else $error("selected count above line count");

  // end of input clears the counters
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_kind_r == lrmf_pkg::KIND_END)) |=> (lines_r == '0 && sel_r == '0))
    else $error("counters not cleared after end of input");

  // line length stays below the limit
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(LINE_LIMIT - 1))
    else $error("line length beyond limit");
`endif

endmodule

FILE: src/lrmf_res_fifo.sv
// ----------------------------------------------------------------------------
// lrmf_res_fifo
// Small result queue: takes up to two beats a cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
module lrmf_res_fifo #(
  parameter int DEPTH = lrmf_pkg::RES_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lrmf_pkg::push_t            push,
  input  lrmf_pkg::res_t             res0,
  input  lrmf_pkg::res_t             res1,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lrmf_pkg::res_t             out_res,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lrmf_pkg::res_t  mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wptr_p1;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop       = out_valid & out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rptr_r];
  assign count     = count_r;
  assign wptr_p1   = ptr_inc(wptr_r);

  // Pointer and fill update
  always_comb begin
    wptr_nxt = wptr_r;
    if (push.second) begin
      wptr_nxt = ptr_inc(wptr_p1);
    end else if (push.first) begin
      wptr_nxt = wptr_p1;
    end
    rptr_nxt  = pop ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r + CW'(push.first) + CW'(push.second) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wptr_r] <= res0;
    end
    if (push.second) begin
      mem_r[wptr_p1] <= res1;
    end
  end

`ifndef SYNTHESIS
  // never written beyond capacity
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW+1)'(count_r) + (CW+1)'(push.first) + (CW+1)'(push.second)) <=
    ((CW+1)'(DEPTH) + (CW+1)'(pop)))
    else $error("result queue overflow");

  // a second beat is only pushed with a first
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second beat without first");

  // fill level stays within the queue
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue fill beyond depth");
`endif

endmodule

FILE: src/line_regex_match_filter_top.sv
// ----------------------------------------------------------------------------
// line_regex_match_filter_top
// Line splitter and small pattern matcher over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per byte; in_tuser=0 carries a data byte in in_tdata,
//           in_tuser=1 marks end of input (in_tdata ignored).
//   out_* : one beat per finished line, plus a summary (out_tuser=1) at end
//           of input; out_tlast marks the final beat caused by an input beat.
//   cfg_* : register writes, taken whenever cfg_we is high; write only while
//           the block is idle.
// Throughput: one byte per cycle while in_tready is high. The whole position
//   update sits between the input register and the result queue, so nothing
//   iterates.
// Path: input register, then result queue. End of input gives up to two
//   beats, drained one per cycle from the queue while out_tready is high.
// Stalls: the 8-entry result queue keeps taking bytes while out_tready is
//   low; in_tready drops once fewer than two free entries would remain.
// Reset: registers clear to zero, line state and counters clear, queue empty.
// ----------------------------------------------------------------------------
module line_regex_match_filter_top #(
  parameter int PATTERN_ELEMENTS = lrmf_pkg::DEF_PATTERN_ELEMENTS,
  parameter int LINE_LIMIT       = lrmf_pkg::DEF_LINE_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [0] line_selected, [32:1] line_number,
                                  // [64:33] selected_count, [65] exit_status
  output logic        out_tuser,  // [0] is_summary
  output logic        out_tlast,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int DEPTH = lrmf_pkg::RES_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1);

  lrmf_pkg::cfg_t  cfg_r;
  lrmf_pkg::push_t push;
  lrmf_pkg::res_t  res0;
  lrmf_pkg::res_t  res1;
  lrmf_pkg::res_t  out_res;
  logic [CW-1:0]   fifo_count;
  logic            core_busy;
  logic [CW:0]     credit;
  logic            in_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (lrmf_pkg::cfg_idx_t'(cfg_index))
        lrmf_pkg::CFG_CHARS:    cfg_r.chars    <= cfg_wdata;
        lrmf_pkg::CFG_ANY:      cfg_r.any      <= cfg_wdata[7:0];
        lrmf_pkg::CFG_STAR:     cfg_r.star     <= cfg_wdata[7:0];
        lrmf_pkg::CFG_LENGTH:   cfg_r.length   <= cfg_wdata[3:0];
        lrmf_pkg::CFG_ANCHORED: cfg_r.anchored <= cfg_wdata[0];
        lrmf_pkg::CFG_ICASE:    cfg_r.icase    <= cfg_wdata[0];
        lrmf_pkg::CFG_INVERT:   cfg_r.invert   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Accept while the queue can hold the beats of the item in flight and this one
  assign credit    = (CW+1)'(fifo_count) + (core_busy ? (CW+1)'(2) : '0);
  assign in_tready = (credit <= (CW+1)'(DEPTH - 2));
  assign in_load   = in_tvalid & in_tready;

  lrmf_core #(
    .PATTERN_ELEMENTS (PATTERN_ELEMENTS),
    .LINE_LIMIT       (LINE_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_load (in_load),
    .in_kind (in_tuser),
    .in_byte (in_tdata),
    .cfg     (cfg_r),
    .busy    (core_busy),
    .push    (push),
    .res0    (res0),
    .res1    (res1)
  );

  lrmf_res_fifo #(
    .DEPTH (DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .count     (fifo_count)
  );

  // Result beat packing
  assign out_tdata = {6'b0, out_res.exit_status, out_res.selected_count,
                      out_res.line_number, out_res.line_selected};
  assign out_tuser = out_res.is_summary;
  assign out_tlast = out_res.last;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line pattern match filter.
// Bytes are streamed in under randomly changing pattern settings, every
// accepted beat is run through a software copy of the line splitter and
// matcher, and each result beat is compared with the oldest prediction.
// Both stream sides see random gaps and stalls; registers change only while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX    = lrmf_pkg::DEF_LINE_LIMIT;
  localparam int ELEMS       = lrmf_pkg::DEF_PATTERN_ELEMENTS;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_BEATS = 50;
  localparam int PHASES      = 12;

  // --------------------------------------------------------------------------
  // Line match predictor and store of pending results
  // --------------------------------------------------------------------------
  class match_scoreboard;
    // register copy
    logic [63:0] chars;
    logic [7:0]  any_mask;
    logic [7:0]  star_mask;
    logic [3:0]  plen;
    logic        anch;
    logic        icase;
    logic        inv;
    // line state
    logic [8:0]  active;
    logic        found;
    logic        nul;
    int unsigned llen;
    logic [31:0] lines;
    logic [31:0] sel;
    // pending results, oldest first
    lrmf_pkg::res_t line_results[$];
    int          errors;
    int          shown;
    int          n_checked;

    function new();
      chars = '0; any_mask = '0; star_mask = '0; plen = '0;
      anch = 1'b0; icase = 1'b0; inv = 1'b0;
      lines = '0; sel = '0;
      errors = 0; shown = 0; n_checked = 0;
      line_start();
    endfunction

    function void line_start();
      active = 9'd1;
      found  = 1'b0;
      nul    = 1'b0;
      llen   = 0;
    endfunction

    function int eff_len();
      return (plen > ELEMS) ? ELEMS : int'(plen);
    endfunction

    function logic [7:0] fold_byte(logic [7:0] c);
      if (icase && c >= "A" && c <= "Z") return c + 8'd32;
      return c;
    endfunction

    // starred positions may be skipped
    function logic [8:0] close_set(logic [8:0] s);
      int n;
      n = eff_len();
      for (int i = 0; i < n; i++)
        if (s[i] && star_mask[i]) s[i+1] = 1'b1;
      return s;
    endfunction

    function void write_cfg(lrmf_pkg::cfg_idx_t idx, logic [63:0] v);
      case (idx)
        lrmf_pkg::CFG_CHARS:    chars     = v;
        lrmf_pkg::CFG_ANY:      any_mask  = v[7:0];
        lrmf_pkg::CFG_STAR:     star_mask = v[7:0];
        lrmf_pkg::CFG_LENGTH:   plen      = v[3:0];
        lrmf_pkg::CFG_ANCHORED: anch      = v[0];
        lrmf_pkg::CFG_ICASE:    icase     = v[0];
        lrmf_pkg::CFG_INVERT:   inv       = v[0];
        default: ;
      endcase
    endfunction

    function void push_result(logic summ, logic selected, logic [31:0] num, logic last);
      lrmf_pkg::res_t r;
      r.is_summary     = summ;
      r.line_selected  = selected;
      r.line_number    = num;
      r.selected_count = sel;
      r.exit_status    = (sel == 0);
      r.last           = last;
      line_results.push_back(r);
    endfunction

    function void close_line(logic last);
      logic [8:0] s;
      logic       m;
      s = close_set(active);
      m = found || s[eff_len()];
      if (inv) m = !m;
      if (lines != lrmf_pkg::CNT_MAX) lines++;
      if (m && sel != lrmf_pkg::CNT_MAX) sel++;
      push_result(1'b0, m, lines, last);
      line_start();
    endfunction

    function void feed_byte(logic [7:0] b);
      logic [8:0] cur;
      logic [8:0] nxt;
      logic [7:0] tb;
      logic [7:0] pc;
      int         n;
      n = eff_len();
      if (llen != 32'hFFFF_FFFF) llen++;
      if (nul) return;
      cur = close_set(active);
      if (cur[n]) found = 1'b1;
      if (b == lrmf_pkg::CHAR_NUL) begin
        nul = 1'b1;
        return;
      end
      tb  = fold_byte(b);
      nxt = '0;
      for (int i = 0; i < n; i++) begin
        if (cur[i]) begin
          pc = fold_byte(chars[8*i +: 8]);
          if (any_mask[i] || pc == tb) begin
            if (star_mask[i]) nxt[i] = 1'b1;
            else nxt[i+1] = 1'b1;
          end
        end
      end
      if (!anch) nxt[0] = 1'b1;
      active = nxt;
    endfunction

    // one accepted input beat
    function void note_input(lrmf_pkg::kind_t k, logic [7:0] b);
      if (k == lrmf_pkg::KIND_END) begin
        if (llen > 0) close_line(1'b0);
        push_result(1'b1, 1'b0, lines, 1'b1);
        line_start();
        lines = '0;
        sel   = '0;
        return;
      end
      if (b == lrmf_pkg::CHAR_NL) begin
        close_line(1'b1);
        return;
      end
      if (llen >= LINE_MAX - 1) close_line(1'b1);
      feed_byte(b);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (shown < 40) begin
        shown++;
        $display("mismatch: %s", msg);
      end
    endtask

    // one accepted result beat
    task check_result(lrmf_pkg::res_t got);
      lrmf_pkg::res_t e;
      n_checked++;
      if (line_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", n_checked));
        return;
      end
      e = line_results.pop_front();
      if (got.is_summary !== e.is_summary || got.line_selected !== e.line_selected ||
          got.line_number !== e.line_number || got.selected_count !== e.selected_count ||
          got.exit_status !== e.exit_status || got.last !== e.last)
        report_mismatch($sformatf(
          {"res %0d got sum=%0b sel=%0b line=%0d cnt=%0d exit=%0b last=%0b ",
           "want %0b %0b %0d %0d %0b %0b"},
          n_checked, got.is_summary, got.line_selected, got.line_number, got.selected_count,
          got.exit_status, got.last, e.is_summary, e.line_selected, e.line_number,
          e.selected_count, e.exit_status, e.last));
    endtask

    function int pending();
      return line_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals, clock, instance
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  match_scoreboard sb = new();
  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_regex_match_filter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(int min_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return min_len;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, check every accepted beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lrmf_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.is_summary     = out_tuser;
      got.line_selected  = out_tdata[0];
      got.line_number    = out_tdata[32:1];
      got.selected_count = out_tdata[64:33];
      got.exit_status    = out_tdata[65];
      got.last           = out_tlast;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap(1) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  int phase_beats = 0;

  task automatic send_beat(lrmf_pkg::kind_t k, logic [7:0] b);
    int gap;
    gap = idle_on ? pick_gap(0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(k, b);
    phase_beats++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(lrmf_pkg::KIND_DATA, b);
  endtask

  // drain everything, then allow for bytes still in flight
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(lrmf_pkg::cfg_idx_t idx, logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_cfg(idx, v);
    @(posedge clk);
  endtask

  task automatic write_config(lrmf_pkg::cfg_t c);
    put_reg(lrmf_pkg::CFG_CHARS, c.chars);
    put_reg(lrmf_pkg::CFG_ANY, 64'(c.any));
    put_reg(lrmf_pkg::CFG_STAR, 64'(c.star));
    put_reg(lrmf_pkg::CFG_LENGTH, 64'(c.length));
    put_reg(lrmf_pkg::CFG_ANCHORED, 64'(c.anchored));
    put_reg(lrmf_pkg::CFG_ICASE, 64'(c.icase));
    put_reg(lrmf_pkg::CFG_INVERT, 64'(c.invert));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pat_char();
    logic [7:0] r;
    case ($urandom_range(0, 7))
      0: return "a";
      1: return "b";
      2: return "c";
      3: return "A";
      4: return "B";
      5: return ".";
      default: begin
        r = 8'($urandom_range(0, 255));
        return (r == lrmf_pkg::CHAR_NL) ? 8'hFF : r;
      end
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0: return "a";
      1: return "b";
      2: return "c";
      3: return "A";
      4: return "B";
      5: return "C";
      6: return ".";
      7: return "*";
      8: return "^";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // bytes that the current pattern should match
  task automatic send_pattern_copy();
    int         reps;
    logic [7:0] b;
    for (int i = 0; i < sb.eff_len(); i++) begin
      reps = sb.star_mask[i] ? $urandom_range(0, 2) : 1;
      repeat (reps) begin
        b = sb.any_mask[i] ? text_byte() : sb.chars[8*i +: 8];
        if (sb.icase && $urandom_range(0, 1) == 1 &&
            ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")))
          b = b ^ 8'h20;
        send_byte(b);
      end
    end
  endtask

  // one line of random text, usually carrying a copy of the pattern
  task automatic send_line();
    repeat ($urandom_range(0, 4)) send_byte(text_byte());
    if ($urandom_range(0, 99) < 3) send_byte(lrmf_pkg::CHAR_NUL);
    if ($urandom_range(0, 99) < 60) send_pattern_copy();
    repeat ($urandom_range(0, 3)) send_byte(text_byte());
    if ($urandom_range(0, 99) < 4) send_beat(lrmf_pkg::KIND_END, 8'($urandom_range(0, 255)));
    else if ($urandom_range(0, 9) != 0) send_byte(lrmf_pkg::CHAR_NL);
  endtask

  function automatic lrmf_pkg::cfg_t random_config(int p);
    lrmf_pkg::cfg_t c;
    for (int i = 0; i < 8; i++) c.chars[8*i +: 8] = pat_char();
    c.any      = 8'($urandom) & 8'($urandom);
    c.star     = 8'($urandom) & 8'($urandom);
    c.length   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(1, 8));
    c.anchored = 1'($urandom_range(0, 1));
    c.icase    = 1'($urandom_range(0, 1));
    c.invert   = 1'($urandom_range(0, 1));
    // extremes on some phases
    case (p)
      0: begin c.chars = '0; c.any = '0; c.star = '0; c.length = 4'd0; end
      1: begin c.chars = '1; c.any = '1; c.length = 4'd8; end
      2: begin c.star = '1; c.length = 4'd15; end
      3: begin c.any = '1; c.star = '1; c.length = 4'd8; end
      4: begin c.anchored = 1'b1; c.icase = 1'b1; c.invert = 1'b1; end
      5: begin c.anchored = 1'b0; c.icase = 1'b0; c.invert = 1'b0; c.length = 4'd1; end
      default: ;
    endcase
    return c;
  endfunction

  // a line of n_bytes non-newline bytes (the limit is LINE_MAX-1), optional NUL inside
  task automatic send_long_line(int n_bytes, bit with_nul);
    logic [7:0] b;
    for (int i = 0; i < n_bytes; i++) begin
      b = 8'($urandom_range(1, 255));
      if (b == lrmf_pkg::CHAR_NL) b = "a";
      if (with_nul && i == 1000) b = lrmf_pkg::CHAR_NUL;
      send_byte(b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    lrmf_pkg::cfg_t c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty pattern, every line matches
    send_byte("x");
    send_byte(8'hFF);
    send_byte(lrmf_pkg::CHAR_NL);
    send_byte(lrmf_pkg::CHAR_NL);
    send_byte(lrmf_pkg::CHAR_NUL);
    send_byte("q");
    send_beat(lrmf_pkg::KIND_END, 8'hFF);
    wait_idle();

    // anchored "a.*B" with case folding
    c.chars    = {40'h0, 8'h42, 8'h3F, 8'h61};
    c.any      = 8'h02;
    c.star     = 8'h02;
    c.length   = 4'd3;
    c.anchored = 1'b1;
    c.icase    = 1'b1;
    c.invert   = 1'b0;
    write_config(c);
    send_byte("A"); send_byte("z"); send_byte("z"); send_byte("b");
    send_byte(lrmf_pkg::CHAR_NL);
    send_byte("x"); send_byte("a"); send_byte("b"); send_byte(lrmf_pkg::CHAR_NL);
    send_byte("a"); send_byte("b"); send_byte(lrmf_pkg::CHAR_NUL);
    send_byte(lrmf_pkg::CHAR_NL);
    send_beat(lrmf_pkg::KIND_END, 8'h00);
    wait_idle();

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      write_config(random_config(p));
      idle_on = ($urandom_range(0, 3) != 0);
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) send_line();
      if ($urandom_range(0, 1) == 1) send_beat(lrmf_pkg::KIND_END, 8'($urandom_range(0, 255)));
      else send_byte(lrmf_pkg::CHAR_NL);
      wait_idle();
    end

    // line length limit: overflow line with a NUL inside
    c.chars    = {48'h0, 8'h62, 8'h61};
    c.any      = 8'h00;
    c.star     = 8'h00;
    c.length   = 4'd2;
    c.anchored = 1'b0;
    c.icase    = 1'b0;
    c.invert   = 1'b0;
    write_config(c);
    idle_on = 1'b1;
    send_long_line(LINE_MAX + 4, 1'b1);
    send_byte("z");
    send_beat(lrmf_pkg::KIND_END, 8'h5A);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lrmf_pkg.sv
src/lrmf_core.sv
src/lrmf_res_fifo.sv
src/line_regex_match_filter_top.sv
dv/tb_top.sv
